>>> rtl/usv_pkg.sv
`default_nettype none

package usv_pkg;

  localparam int CountBits = 32;

  localparam int ValBits = 21;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [ValBits-1:0]   val_t;
  typedef logic [2:0]           err_t;

  localparam err_t E_NONE      = 3'd0;
  localparam err_t E_BAD_LEAD  = 3'd1;
  localparam err_t E_BAD_2ND   = 3'd2;
  localparam err_t E_BAD_3RD   = 3'd3;
  localparam err_t E_BAD_4TH   = 3'd4;
  localparam err_t E_RANGE     = 3'd5;
  localparam err_t E_TRUNCATED = 3'd6;

  localparam logic [7:0] LineFeed = 8'h0a;

  localparam val_t Min2 = val_t'(21'h00080);
  localparam val_t Max2 = val_t'(21'h007ff);
  localparam val_t Min3 = val_t'(21'h00800);
  localparam val_t Max3 = val_t'(21'h0ffff);
  localparam val_t Min4 = val_t'(21'h10000);
  localparam val_t Max4 = val_t'(21'h10ffff);

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : count_t'(v + count_t'(1));
  endfunction

  function automatic logic [31:0] clip32(input count_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : w[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_stream_validator_core.sv
`default_nettype none
// pipeline: an accepted transaction is held in the input register, decoded, and its
// result written into the result register that drives the outputs; out_stall holds both
// throughput: one byte per cycle while out_stall is low, set by the single-pass decode
// between the input register and the result register
// reset: synchronous active-low rst_n clears the pipeline valids and puts the
// decoder, counters and error hold back to the start-of-stream state

module utf8_stream_validator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_last_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_stream_done,
  output      logic        out_stream_ok,
  output      logic [2:0]  out_error_code,
  output      logic [31:0] out_error_offset,
  output      logic [31:0] out_error_line
);

  localparam logic [2:0] S_LEAD  = 3'd0;
  localparam logic [2:0] S_2B1   = 3'd1;
  localparam logic [2:0] S_3B1   = 3'd2;
  localparam logic [2:0] S_3B2   = 3'd3;
  localparam logic [2:0] S_4B1   = 3'd4;
  localparam logic [2:0] S_4B2   = 3'd5;
  localparam logic [2:0] S_4B3   = 3'd6;
  localparam logic [2:0] S_SPARE = 3'd7;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       s1_fire;
  logic       in_fire;

  // stream state
  logic [2:0]      seq_state_r, seq_state_nxt;
  usv_pkg::val_t   partial_r, partial_nxt;
  usv_pkg::count_t byte_offset_r, byte_offset_nxt;
  usv_pkg::count_t line_count_r, line_count_nxt;
  usv_pkg::err_t   err_latched_r, err_latched_nxt;
  usv_pkg::count_t err_offset_r, err_offset_nxt;
  usv_pkg::count_t err_line_r, err_line_nxt;

  // result register
  logic        out_valid_r;
  logic        done_r;
  logic        ok_r;
  logic [2:0]  code_r;
  logic [31:0] eoff_r;
  logic [31:0] eline_r;

  logic          done_c;
  logic          cont_c;
  usv_pkg::val_t shifted_c;
  usv_pkg::err_t latch_code;
  usv_pkg::err_t final_err;
  usv_pkg::count_t final_eoff;
  usv_pkg::count_t final_eline;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte_in;
      s1_last_r <= in_last_byte;
    end
  end

  assign cont_c    = (s1_byte_r[7:6] == 2'b10);
  assign shifted_c = {partial_r[usv_pkg::ValBits-7:0], s1_byte_r[5:0]};

  // decode one byte
  always_comb begin
    seq_state_nxt   = seq_state_r;
    partial_nxt     = partial_r;
    line_count_nxt  = line_count_r;
    byte_offset_nxt = byte_offset_r;
    latch_code      = usv_pkg::E_NONE;
    done_c          = 1'b0;

    if (s1_byte_r == 8'd0) begin
      done_c = 1'b1;
    end else begin
      if (err_latched_r == usv_pkg::E_NONE) begin
        unique case (seq_state_r) inside
          S_2B1, S_3B1, S_4B1: begin
            if (!cont_c) latch_code = usv_pkg::E_BAD_2ND;
          end
          S_3B2, S_4B2: begin
            if (!cont_c) latch_code = usv_pkg::E_BAD_3RD;
          end
          S_4B3: begin
            if (!cont_c) latch_code = usv_pkg::E_BAD_4TH;
          end
          default: begin
            if (s1_byte_r < 8'h80) begin
              if (s1_byte_r == usv_pkg::LineFeed) begin
                line_count_nxt = usv_pkg::sat_inc(line_count_r);
              end
              seq_state_nxt = S_LEAD;
            end else if (s1_byte_r < 8'hc0) begin
              latch_code = usv_pkg::E_BAD_LEAD;
            end else if (s1_byte_r < 8'he0) begin
              partial_nxt   = usv_pkg::val_t'(s1_byte_r[4:0]);
              seq_state_nxt = S_2B1;
            end else if (s1_byte_r < 8'hf0) begin
              partial_nxt   = usv_pkg::val_t'(s1_byte_r[3:0]);
              seq_state_nxt = S_3B1;
            end else if (s1_byte_r < 8'hf8) begin
              partial_nxt   = usv_pkg::val_t'(s1_byte_r[2:0]);
              seq_state_nxt = S_4B1;
            end else begin
              latch_code = usv_pkg::E_BAD_LEAD;
            end
          end
        endcase

        if (cont_c && seq_state_r != S_LEAD && seq_state_r != S_SPARE) begin
          partial_nxt = shifted_c;
          unique case (seq_state_r)
            S_2B1: begin
              if (shifted_c < usv_pkg::Min2 || shifted_c > usv_pkg::Max2)
                latch_code = usv_pkg::E_RANGE;
              else
                seq_state_nxt = S_LEAD;
            end
            S_3B2: begin
              if (shifted_c < usv_pkg::Min3 || shifted_c > usv_pkg::Max3)
                latch_code = usv_pkg::E_RANGE;
              else
                seq_state_nxt = S_LEAD;
            end
            S_4B3: begin
              if (shifted_c < usv_pkg::Min4 || shifted_c > usv_pkg::Max4)
                latch_code = usv_pkg::E_RANGE;
              else
                seq_state_nxt = S_LEAD;
            end
            S_3B1:   seq_state_nxt = S_3B2;
            S_4B1:   seq_state_nxt = S_4B2;
            default: seq_state_nxt = S_4B3;
          endcase
        end

        if (latch_code != usv_pkg::E_NONE) begin
          seq_state_nxt = S_LEAD;
        end
      end
      byte_offset_nxt = usv_pkg::sat_inc(byte_offset_r);
      done_c          = s1_last_r;
    end

    final_err   = err_latched_r;
    final_eoff  = err_offset_r;
    final_eline = err_line_r;
    if (latch_code != usv_pkg::E_NONE) begin
      final_err   = latch_code;
      final_eoff  = byte_offset_r;
      final_eline = line_count_r;
    end
    // stream ended mid-sequence
    if (done_c && final_err == usv_pkg::E_NONE && seq_state_nxt != S_LEAD) begin
      final_err     = usv_pkg::E_TRUNCATED;
      final_eoff    = byte_offset_nxt;
      final_eline   = line_count_nxt;
      seq_state_nxt = S_LEAD;
    end

    err_latched_nxt = final_err;
    err_offset_nxt  = final_eoff;
    err_line_nxt    = final_eline;

    if (done_c) begin
      seq_state_nxt   = S_LEAD;
      partial_nxt     = '0;
      byte_offset_nxt = '0;
      line_count_nxt  = usv_pkg::count_t'(1);
      err_latched_nxt = usv_pkg::E_NONE;
      err_offset_nxt  = '0;
      err_line_nxt    = usv_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r   <= S_LEAD;
      partial_r     <= '0;
      byte_offset_r <= '0;
      line_count_r  <= usv_pkg::count_t'(1);
      err_latched_r <= usv_pkg::E_NONE;
      err_offset_r  <= '0;
      err_line_r    <= usv_pkg::count_t'(1);
    end else if (s1_fire) begin
      seq_state_r   <= seq_state_nxt;
      partial_r     <= partial_nxt;
      byte_offset_r <= byte_offset_nxt;
      line_count_r  <= line_count_nxt;
      err_latched_r <= err_latched_nxt;
      err_offset_r  <= err_offset_nxt;
      err_line_r    <= err_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      done_r  <= done_c;
      ok_r    <= done_c && (final_err == usv_pkg::E_NONE);
      code_r  <= final_err;
      eoff_r  <= usv_pkg::clip32(final_eoff);
      eline_r <= usv_pkg::clip32(final_eline);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stream_done  = done_r;
  assign out_stream_ok    = ok_r;
  assign out_error_code   = code_r;
  assign out_error_offset = eoff_r;
  assign out_error_line   = eline_r;

`ifndef NO_ASSERTIONS
  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    seq_state_r != S_SPARE)
    else $error("sequence state left the legal codes");

  a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stream_ok) |-> (out_stream_done && out_error_code == usv_pkg::E_NONE))
    else $error("stream ok reported with an error or without end of stream");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && done_c) |=> (err_latched_r == usv_pkg::E_NONE && byte_offset_r == '0
                             && seq_state_r == S_LEAD))
    else $error("stream state not cleared after end of stream");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_latched_r != usv_pkg::E_NONE && !(s1_fire && done_c)) |=> $stable(err_latched_r))
    else $error("latched error changed inside a stream");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while the pipeline has room");
`endif

endmodule

`default_nettype wire
